// ----- rtl/bda_pkg.sv -----
// shared types, codes and defaults for the deadlock-avoidance unit
// depends on nothing; used by bda_ctrl, bda_dp and the top level
package bda_pkg;

  // default sizes handed to the top-level parameters
  localparam int MaxProcsDef   = 16;
  localparam int MaxResDef     = 8;
  localparam int CountWidthDef = 16;

  // register reset values
  localparam logic [4:0] ProcCountRst = 5'd16;
  localparam logic [3:0] ResCountRst  = 4'd8;

  // register indexes (paddr bit 2)
  localparam logic RegProcCount = 1'b0;
  localparam logic RegResCount  = 1'b1;

  // input opcodes
  typedef enum logic [2:0] {
    OP_LOAD_CLAIM = 3'd0,
    OP_LOAD_ALLOC = 3'd1,
    OP_LOAD_AVAIL = 3'd2,
    OP_REQUEST    = 3'd3,
    OP_CHECK      = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_LOADED     = 3'd0,
    ST_OVER_CLAIM = 3'd1,
    ST_SAFE       = 3'd2,
    ST_UNSAFE     = 3'd3,
    ST_OVER_NEED  = 3'd4,
    ST_OVER_AVAIL = 3'd5,
    ST_GRANTED    = 3'd6,
    ST_REFUSED    = 3'd7
  } st_e;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic latch;
    logic rd_item;
    logic rd_scan;
    logic avail_load;
    logic buf_load;
    logic buf_clear;
    logic ld_update;
    logic req_eval;
    logic work_init;
    logic scan_skip;
    logic scan_test;
    logic rollback;
    logic st_set;
    st_e  st_val;
    logic emit_single;
    logic emit_seq;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic fin;
    logic pin;
    logic req_fail;
    logic scan_done;
    logic cur_finished;
    logic safe;
    logic slot_free;
    logic seq_last;
    logic clr_last;
  } stat_t;

endpackage

// ----- rtl/bda_ctrl.sv -----
// controller state machine of the deadlock-avoidance unit
// depends on bda_pkg; drives bda_dp through cmd_t and reads stat_t
module bda_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bda_pkg::stat_t stat_i,
  output bda_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DECODE = 11'b00000000100,
    S_LDWR   = 11'b00000001000,
    S_REQCHK = 11'b00000010000,
    S_INIT   = 11'b00000100000,
    S_SCAN   = 11'b00001000000,
    S_TEST   = 11'b00010000000,
    S_END    = 11'b00100000000,
    S_EMIT1  = 11'b01000000000,
    S_SEQ    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.st_val = bda_pkg::ST_LOADED;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.op)
          bda_pkg::OP_LOAD_CLAIM, bda_pkg::OP_LOAD_ALLOC: begin
            cmd_o.rd_item = 1'b1;
            state_d       = S_LDWR;
          end
          bda_pkg::OP_LOAD_AVAIL: begin
            cmd_o.avail_load = 1'b1;
            cmd_o.st_set     = 1'b1;
            state_d          = S_EMIT1;
          end
          bda_pkg::OP_REQUEST: begin
            cmd_o.buf_load = 1'b1;
            if (!stat_i.fin) begin
              cmd_o.st_set = 1'b1;
              state_d      = S_EMIT1;
            end else if (!stat_i.pin) begin
              cmd_o.st_set    = 1'b1;
              cmd_o.st_val    = bda_pkg::ST_OVER_NEED;
              cmd_o.buf_clear = 1'b1;
              state_d         = S_EMIT1;
            end else begin
              cmd_o.rd_item = 1'b1;
              state_d       = S_REQCHK;
            end
          end
          bda_pkg::OP_CHECK: begin
            state_d = S_INIT;
          end
          default: begin
            cmd_o.st_set = 1'b1;
            state_d      = S_EMIT1;
          end
        endcase
      end
      S_LDWR: begin
        cmd_o.ld_update = 1'b1;
        state_d         = S_EMIT1;
      end
      S_REQCHK: begin
        cmd_o.req_eval = 1'b1;
        if (stat_i.req_fail) begin
          cmd_o.buf_clear = 1'b1;
          state_d         = S_EMIT1;
        end else begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        cmd_o.work_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = S_END;
        end else if (stat_i.cur_finished) begin
          cmd_o.scan_skip = 1'b1;
        end else begin
          cmd_o.rd_scan = 1'b1;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        cmd_o.scan_test = 1'b1;
        state_d         = S_SCAN;
      end
      S_END: begin
        cmd_o.st_set = 1'b1;
        if (stat_i.op == bda_pkg::OP_REQUEST) begin
          cmd_o.buf_clear = 1'b1;
          if (stat_i.safe) begin
            cmd_o.st_val = bda_pkg::ST_GRANTED;
            state_d      = S_SEQ;
          end else begin
            cmd_o.rollback = 1'b1;
            cmd_o.st_val   = bda_pkg::ST_REFUSED;
            state_d        = S_EMIT1;
          end
        end else if (stat_i.safe) begin
          cmd_o.st_val = bda_pkg::ST_SAFE;
          state_d      = S_SEQ;
        end else begin
          cmd_o.st_val = bda_pkg::ST_UNSAFE;
          state_d      = S_EMIT1;
        end
      end
      S_EMIT1: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_SEQ: begin
        if (stat_i.slot_free) begin
          cmd_o.emit_seq = 1'b1;
          if (stat_i.seq_last) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bda_dp.sv -----
// datapath of the deadlock-avoidance unit: tables, work vector, scan and output register
// depends on bda_pkg; controlled by bda_ctrl through cmd_t
module bda_dp #(
  parameter int MAX_PROCS   = bda_pkg::MaxProcsDef,
  parameter int MAX_RES     = bda_pkg::MaxResDef,
  parameter int COUNT_WIDTH = bda_pkg::CountWidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     proc_count_i,
  input  logic [3:0]     res_count_i,
  input  logic [2:0]     opcode_i,
  input  logic [3:0]     process_i,
  input  logic [2:0]     resource_i,
  input  logic [15:0]    amount_i,
  input  logic           final_element_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic [2:0]     status_o,
  output logic [3:0]     order_process_o,
  output logic           last_o,
  input  bda_pkg::cmd_t  cmd_i,
  output bda_pkg::stat_t stat_o
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int MW = $clog2(MAX_PROCS + 1);
  localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int NW = $clog2(MAX_RES + 1);
  localparam int WW = COUNT_WIDTH + 4;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef cnt_t [MAX_RES-1:0] row_t;

  // allocation and remaining-need tables, one row per process
  row_t alloc_mem [MAX_PROCS];
  row_t need_mem  [MAX_PROCS];
  row_t rd_alloc_q, rd_need_q;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  row_t          wr_alloc, wr_need;

  // latched item
  logic [2:0]  op_q;
  logic [3:0]  p_q;
  logic [2:0]  r_q;
  cnt_t        amt_q;
  logic        fin_q;

  // small state
  row_t                       avail_q, avail_d;
  row_t                       buf_q, buf_d;
  row_t                       hold_alloc_q, hold_need_q;
  logic [MAX_RES-1:0][WW-1:0] work_q, work_d;
  logic [MAX_RES-1:0][WW:0]   work_sum;
  logic [MAX_PROCS-1:0]       fmask_q, fmask_d;
  logic [PW-1:0]              seq_q [MAX_PROCS];
  logic [MW-1:0]              i_q, i_d, len_q, len_d;
  logic [PW-1:0]              k_q, k_d, clr_q;
  bda_pkg::st_e               st_q, st_d;

  // output register
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [3:0] order_q;
  logic       last_q;

  logic [MW-1:0] m_used;
  logic [NW-1:0] n_used;
  logic          pin, rin;
  logic [RW-1:0] ridx;
  logic [PW-1:0] pidx, iidx;
  logic          slot_free;

  // clamped process and resource counts
  always_comb begin
    if (proc_count_i == 5'd0) m_used = MW'(1);
    else if (32'(proc_count_i) > MAX_PROCS) m_used = MW'(MAX_PROCS);
    else m_used = MW'(proc_count_i);
    if (res_count_i == 4'd0) n_used = NW'(1);
    else if (32'(res_count_i) > MAX_RES) n_used = NW'(MAX_RES);
    else n_used = NW'(res_count_i);
  end

  assign pin  = 32'(p_q) < 32'(m_used);
  assign rin  = 32'(r_q) < 32'(n_used);
  assign ridx = RW'(r_q);
  assign pidx = PW'(p_q);
  assign iidx = PW'(i_q);

  // table memories
  assign rd_en   = cmd_i.rd_item | cmd_i.rd_scan;
  assign rd_addr = cmd_i.rd_scan ? iidx : pidx;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      alloc_mem[wr_addr] <= wr_alloc;
      need_mem[wr_addr]  <= wr_need;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_alloc_q <= alloc_mem[rd_addr];
      rd_need_q  <= need_mem[rd_addr];
    end
  end

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      p_q   <= process_i;
      r_q   <= resource_i;
      amt_q <= COUNT_WIDTH'(amount_i);
      fin_q <= final_element_i;
    end
  end

  // claim and allocation load update
  cnt_t                 ld_a, ld_n;
  logic [COUNT_WIDTH:0] ld_claim;
  logic                 ld_bad;
  row_t                 ld_alloc, ld_need;

  always_comb begin
    ld_a     = rd_alloc_q[ridx];
    ld_n     = rd_need_q[ridx];
    ld_claim = {1'b0, ld_a} + {1'b0, ld_n};
    ld_alloc = rd_alloc_q;
    ld_need  = rd_need_q;
    if (op_q == bda_pkg::OP_LOAD_CLAIM) begin
      ld_bad        = amt_q < ld_a;
      ld_need[ridx] = amt_q - ld_a;
    end else begin
      ld_bad         = {1'b0, amt_q} > ld_claim;
      ld_alloc[ridx] = amt_q;
      ld_need[ridx]  = COUNT_WIDTH'(ld_claim - {1'b0, amt_q});
    end
  end

  // request check against need and available, lowest resource first
  logic         req_fail;
  bda_pkg::st_e fail_code;
  row_t         com_alloc, com_need;

  always_comb begin
    req_fail  = 1'b0;
    fail_code = bda_pkg::ST_OVER_NEED;
    for (int j = MAX_RES - 1; j >= 0; j--) begin
      if (j < int'(n_used) && (buf_q[j] > rd_need_q[j] || buf_q[j] > avail_q[j])) begin
        req_fail  = 1'b1;
        fail_code = (buf_q[j] > rd_need_q[j]) ? bda_pkg::ST_OVER_NEED
                                              : bda_pkg::ST_OVER_AVAIL;
      end
    end
    for (int j = 0; j < MAX_RES; j++) begin
      if (j < int'(n_used)) begin
        com_alloc[j] = rd_alloc_q[j] + buf_q[j];
        com_need[j]  = rd_need_q[j] - buf_q[j];
      end else begin
        com_alloc[j] = rd_alloc_q[j];
        com_need[j]  = rd_need_q[j];
      end
    end
  end

  // write port selection
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = pidx;
    wr_alloc = rd_alloc_q;
    wr_need  = rd_need_q;
    if (cmd_i.clr_step) begin
      wr_en    = 1'b1;
      wr_addr  = clr_q;
      wr_alloc = '0;
      wr_need  = '0;
    end else if (cmd_i.ld_update) begin
      wr_en    = pin & rin & ~ld_bad;
      wr_alloc = ld_alloc;
      wr_need  = ld_need;
    end else if (cmd_i.req_eval) begin
      wr_en    = ~req_fail;
      wr_alloc = com_alloc;
      wr_need  = com_need;
    end else if (cmd_i.rollback) begin
      wr_en    = 1'b1;
      wr_alloc = hold_alloc_q;
      wr_need  = hold_need_q;
    end
  end

  // row fits in work and saturating work update
  logic fits;

  always_comb begin
    fits = 1'b1;
    for (int j = 0; j < MAX_RES; j++) begin
      work_sum[j] = (WW + 1)'(work_q[j]) + (WW + 1)'(rd_alloc_q[j]);
      if (j < int'(n_used) && WW'(rd_need_q[j]) > work_q[j]) fits = 1'b0;
    end
  end

  // available, buffer, work and scan bookkeeping
  always_comb begin
    avail_d = avail_q;
    buf_d   = buf_q;
    work_d  = work_q;
    fmask_d = fmask_q;
    i_d     = i_q;
    len_d   = len_q;
    k_d     = k_q;
    st_d    = st_q;
    if (cmd_i.avail_load && rin) avail_d[ridx] = amt_q;
    if (cmd_i.buf_load && rin) buf_d[ridx] = amt_q;
    if (cmd_i.buf_clear) buf_d = '0;
    if (cmd_i.req_eval && !req_fail) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (j < int'(n_used)) avail_d[j] = avail_q[j] - buf_q[j];
      end
    end
    if (cmd_i.rollback) begin
      for (int j = 0; j < MAX_RES; j++) begin
        if (j < int'(n_used)) avail_d[j] = avail_q[j] + buf_q[j];
      end
    end
    if (cmd_i.work_init) begin
      for (int j = 0; j < MAX_RES; j++) begin
        work_d[j] = (j < int'(n_used)) ? WW'(avail_q[j]) : '0;
      end
      fmask_d = '0;
      i_d     = '0;
      len_d   = '0;
      k_d     = '0;
    end
    if (cmd_i.scan_skip) i_d = i_q + MW'(1);
    if (cmd_i.scan_test) begin
      if (fits) begin
        fmask_d[iidx] = 1'b1;
        for (int j = 0; j < MAX_RES; j++) begin
          if (j < int'(n_used)) begin
            work_d[j] = work_sum[j][WW] ? {WW{1'b1}} : work_sum[j][WW-1:0];
          end
        end
        len_d = len_q + MW'(1);
        i_d   = '0;
      end else begin
        i_d = i_q + MW'(1);
      end
    end
    if (cmd_i.emit_seq && slot_free) k_d = k_q + PW'(1);
    if (cmd_i.st_set) st_d = cmd_i.st_val;
    if (cmd_i.ld_update) begin
      st_d = (pin && rin && ld_bad) ? bda_pkg::ST_OVER_CLAIM : bda_pkg::ST_LOADED;
    end
    if (cmd_i.req_eval && req_fail) st_d = fail_code;
  end

  // control and table-state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
      buf_q   <= '0;
      work_q  <= '0;
      fmask_q <= '0;
      i_q     <= '0;
      len_q   <= '0;
      k_q     <= '0;
      clr_q   <= '0;
      st_q    <= bda_pkg::ST_LOADED;
    end else begin
      avail_q <= avail_d;
      buf_q   <= buf_d;
      work_q  <= work_d;
      fmask_q <= fmask_d;
      i_q     <= i_d;
      len_q   <= len_d;
      k_q     <= k_d;
      st_q    <= st_d;
      if (cmd_i.clr_step) clr_q <= clr_q + PW'(1);
    end
  end

  // saved rows for rollback, safe sequence store
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_eval) begin
      hold_alloc_q <= rd_alloc_q;
      hold_need_q  <= rd_need_q;
    end
    if (cmd_i.scan_test && fits) seq_q[PW'(len_q)] <= iidx;
  end

  // output register
  assign slot_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_single || cmd_i.emit_seq) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      status_q <= st_q;
      order_q  <= 4'd0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_seq) begin
      status_q <= st_q;
      order_q  <= 4'(seq_q[k_q]);
      last_q   <= stat_o.seq_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign order_process_o = order_q;
  assign last_o          = last_q;

  // status to controller
  always_comb begin
    stat_o.op           = bda_pkg::op_e'(op_q);
    stat_o.fin          = fin_q;
    stat_o.pin          = pin;
    stat_o.req_fail     = req_fail;
    stat_o.scan_done    = (i_q >= m_used) || (len_q >= m_used);
    stat_o.cur_finished = fmask_q[iidx];
    stat_o.safe         = (len_q == m_used);
    stat_o.slot_free    = slot_free;
    stat_o.seq_last     = (MW'(k_q) + MW'(1)) == len_q;
    stat_o.clr_last     = (clr_q == PW'(MAX_PROCS - 1));
  end

endmodule

// ----- rtl/bankers_deadlock_avoidance.sv -----
// Deadlock-avoidance unit (banker's algorithm). One item is taken at a time. A claim or
// allocation load reads the process row, updates it and writes it back before its result;
// an available load and a non-final request element give their result after decode. A
// stalled output holds the unit until the result is taken. A safety check (opcode 4, or
// a final request element that passes the need and available checks) scans the allocation
// and need tables. These are memories with one row per process. A row test is a row read,
// then all resources compared against work in parallel. A finished process is skipped
// without a read, and the scan restarts at process 0 after each finish. The m results of
// a safe sequence (m processes in use) leave at one per cycle while the output is not
// stalled. After reset every table row is cleared, one row a cycle, with input stalled.
// depends on bda_pkg, bda_ctrl and bda_dp
module bankers_deadlock_avoidance #(
  parameter int MAX_PROCS   = bda_pkg::MaxProcsDef,
  parameter int MAX_RES     = bda_pkg::MaxResDef,
  parameter int COUNT_WIDTH = bda_pkg::CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  process_i,
  input  logic [2:0]  resource_i,
  input  logic [15:0] amount_i,
  input  logic        final_element_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  order_process_o,
  output logic        last_o
);

  logic [4:0]     proc_count_q;
  logic [3:0]     res_count_q;
  bda_pkg::cmd_t  cmd;
  bda_pkg::stat_t stat;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= bda_pkg::ProcCountRst;
      res_count_q  <= bda_pkg::ResCountRst;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bda_pkg::RegProcCount) proc_count_q <= pwdata[4:0];
      else res_count_q <= pwdata[3:0];
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == bda_pkg::RegResCount) prdata = {28'd0, res_count_q};
    else prdata = {27'd0, proc_count_q};
  end

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bda_dp #(
    .MAX_PROCS   (MAX_PROCS),
    .MAX_RES     (MAX_RES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .proc_count_i    (proc_count_q),
    .res_count_i     (res_count_q),
    .opcode_i        (opcode_i),
    .process_i       (process_i),
    .resource_i      (resource_i),
    .amount_i        (amount_i),
    .final_element_i (final_element_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .order_process_o (order_process_o),
    .last_o          (last_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule

// ----- rtl/bda_checker.sv -----
// port-level checks for the deadlock-avoidance unit, bound to the top level
// depends on bda_pkg and on bankers_deadlock_avoidance being compiled first
module bda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [3:0] order_process_o,
  input logic       last_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(order_process_o) && $stable(last_o))
    else $error("stalled result changed");

  // only a safe sequence has more than one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == bda_pkg::ST_SAFE
      || status_o == bda_pkg::ST_GRANTED)
    else $error("non-final result outside a safe sequence");

  // results without a sequence carry process zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bda_pkg::ST_SAFE && status_o != bda_pkg::ST_GRANTED
      |-> order_process_o == 4'd0)
    else $error("order process set on a result without sequence");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

endmodule

bind bankers_deadlock_avoidance bda_checker u_bda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .order_process_o (order_process_o),
  .last_o          (last_o)
);

// ----- tb/bda_checker.sv -----
// scoreboard for the deadlock-avoidance unit: predicts every result and compares it
// depends on bda_pkg; watches the apb port and both channels of bankers_deadlock_avoidance
module bda_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  process_i,
  input  logic [2:0]  resource_i,
  input  logic [15:0] amount_i,
  input  logic        final_element_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [2:0]  status_o,
  input  logic [3:0]  order_process_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_count,
  output int          item_count,
  output int          result_count,
  output int          sequence_count
);

  typedef struct {
    bda_pkg::st_e status;
    logic [3:0]   proc;
    logic         last;
  } bank_result_t;

  localparam logic [19:0] WorkSat = 20'hFFFFF;

  // predicted copy of the unit state
  logic [4:0]  proc_cfg;
  logic [3:0]  res_cfg;
  logic [15:0] avail_cnt [8];
  logic [15:0] alloc_tab [16][8];
  logic [15:0] need_tab  [16][8];
  logic [15:0] req_buf   [8];
  logic [3:0]  safe_order [16];
  int          safe_len;

  bank_result_t expected_q [$];

  function automatic int procs_in_use();
    if (proc_cfg == 0) return 1;
    if (proc_cfg > 16) return 16;
    return int'(proc_cfg);
  endfunction

  function automatic int res_in_use();
    if (res_cfg == 0) return 1;
    if (res_cfg > 8) return 8;
    return int'(res_cfg);
  endfunction

  function automatic void push_result(bda_pkg::st_e st, logic [3:0] pr, logic lst);
    bank_result_t e;
    e.status = st;
    e.proc   = pr;
    e.last   = lst;
    expected_q.push_back(e);
  endfunction

  // greedy scan, restarting at process 0 after each finish
  function automatic bit find_safe_order();
    int m;
    int n;
    int i;
    int j;
    bit fits;
    logic [19:0] work [8];
    logic [15:0] done;
    logic [20:0] sum;
    m = procs_in_use();
    n = res_in_use();
    for (j = 0; j < 8; j++) work[j] = (j < n) ? 20'(avail_cnt[j]) : '0;
    done = '0;
    safe_len = 0;
    i = 0;
    while (i < m && safe_len < m) begin
      if (done[i]) begin
        i++;
        continue;
      end
      fits = 1'b1;
      for (j = 0; j < n; j++) if (20'(need_tab[i][j]) > work[j]) fits = 1'b0;
      if (!fits) begin
        i++;
        continue;
      end
      done[i] = 1'b1;
      for (j = 0; j < n; j++) begin
        sum = 21'(work[j]) + 21'(alloc_tab[i][j]);
        work[j] = (sum > 21'(WorkSat)) ? WorkSat : sum[19:0];
      end
      safe_order[safe_len] = 4'(i);
      safe_len++;
      i = 0;
    end
    return safe_len == m;
  endfunction

  function automatic void push_order(bda_pkg::st_e st);
    int k;
    for (k = 0; k < safe_len; k++) push_result(st, safe_order[k], k == safe_len - 1);
    sequence_count++;
  endfunction

  // one input transaction of the unit
  function automatic void predict_bank_step(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                                            logic [15:0] amt, logic fin);
    bit pin;
    bit rin;
    int n;
    int j;
    bda_pkg::st_e st;
    logic [16:0] claim;
    pin = int'(p) < procs_in_use();
    rin = int'(r) < res_in_use();
    n = res_in_use();
    st = bda_pkg::ST_LOADED;
    case (op)
      bda_pkg::OP_LOAD_CLAIM, bda_pkg::OP_LOAD_ALLOC: begin
        if (pin && rin) begin
          claim = 17'(need_tab[p][r]) + 17'(alloc_tab[p][r]);
          if (op == bda_pkg::OP_LOAD_CLAIM) begin
            if (amt < alloc_tab[p][r]) st = bda_pkg::ST_OVER_CLAIM;
            else need_tab[p][r] = amt - alloc_tab[p][r];
          end else begin
            if (17'(amt) > claim) st = bda_pkg::ST_OVER_CLAIM;
            else begin
              alloc_tab[p][r] = amt;
              need_tab[p][r] = 16'(claim - 17'(amt));
            end
          end
        end
        push_result(st, '0, 1'b1);
      end
      bda_pkg::OP_LOAD_AVAIL: begin
        if (rin) avail_cnt[r] = amt;
        push_result(bda_pkg::ST_LOADED, '0, 1'b1);
      end
      bda_pkg::OP_CHECK: begin
        if (find_safe_order()) push_order(bda_pkg::ST_SAFE);
        else push_result(bda_pkg::ST_UNSAFE, '0, 1'b1);
      end
      bda_pkg::OP_REQUEST: begin
        if (rin) req_buf[r] = amt;
        if (!fin) begin
          push_result(bda_pkg::ST_LOADED, '0, 1'b1);
        end else begin
          if (!pin) st = bda_pkg::ST_OVER_NEED;
          for (j = 0; j < n && st == bda_pkg::ST_LOADED; j++) begin
            if (req_buf[j] > need_tab[p][j]) st = bda_pkg::ST_OVER_NEED;
            else if (req_buf[j] > avail_cnt[j]) st = bda_pkg::ST_OVER_AVAIL;
          end
          if (st == bda_pkg::ST_LOADED) begin
            // tentative commit, undone when the result is unsafe
            for (j = 0; j < n; j++) begin
              avail_cnt[j] -= req_buf[j];
              alloc_tab[p][j] += req_buf[j];
              need_tab[p][j] -= req_buf[j];
            end
            if (find_safe_order()) begin
              push_order(bda_pkg::ST_GRANTED);
            end else begin
              for (j = 0; j < n; j++) begin
                avail_cnt[j] += req_buf[j];
                alloc_tab[p][j] -= req_buf[j];
                need_tab[p][j] += req_buf[j];
              end
              push_result(bda_pkg::ST_REFUSED, '0, 1'b1);
            end
          end else begin
            push_result(st, '0, 1'b1);
          end
          for (j = 0; j < 8; j++) req_buf[j] = '0;
        end
      end
      default: push_result(bda_pkg::ST_LOADED, '0, 1'b1);
    endcase
  endfunction

  // watch config writes, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_cfg = bda_pkg::ProcCountRst;
      res_cfg = bda_pkg::ResCountRst;
      for (int j = 0; j < 8; j++) begin
        avail_cnt[j] = '0;
        req_buf[j] = '0;
        for (int i = 0; i < 16; i++) begin
          alloc_tab[i][j] = '0;
          need_tab[i][j] = '0;
        end
      end
      safe_len = 0;
      expected_q.delete();
      fail_count = 0;
      pending_count = 0;
      item_count = 0;
      result_count = 0;
      sequence_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == bda_pkg::RegResCount) res_cfg = pwdata[3:0];
        else proc_cfg = pwdata[4:0];
      end
      if (in_valid_i && !in_stall_o) begin
        predict_bank_step(opcode_i, process_i, resource_i, amount_i, final_element_i);
        item_count++;
      end
      if (out_valid_o && !out_stall_i) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: status %0d order_process %0d last %0d",
                 status_o, order_process_o, last_o);
          fail_count++;
        end else begin
          bank_result_t e;
          e = expected_q.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, status_o);
            fail_count++;
          end
          if (order_process_o !== e.proc) begin
            $error("order_process: expected %0d actual %0d", e.proc, order_process_o);
            fail_count++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, last_o);
            fail_count++;
          end
        end
      end
      pending_count = expected_q.size();
    end
  end

endmodule

// ----- tb/tb_bankers_deadlock_avoidance.sv -----
// stimulus and verdict for bankers_deadlock_avoidance
// depends on bda_pkg, the unit itself and bda_scoreboard
module tb_bankers_deadlock_avoidance;

  localparam int IdleLimit = 6000;
  localparam int LongHold = 400;
  localparam logic [2:0] OpUnused = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  opcode_i = '0;
  logic [3:0]  process_i = '0;
  logic [2:0]  resource_i = '0;
  logic [15:0] amount_i = '0;
  logic        final_element_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  order_process_o;
  logic        last_o;

  int fail_count;
  int pending_count;
  int item_count;
  int result_count;
  int sequence_count;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int cur_procs;
  int cur_res;

  bankers_deadlock_avoidance uut (.*);

  bda_scoreboard checker_i (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transaction for %0d cycles", IdleLimit);
        $display("[bankers_deadlock_avoidance] ERROR");
        $finish;
      end
    end
  end

  // result side: random stall per result, one long hold on request
  initial begin
    int d;
    @(posedge rst_ni);
    forever begin
      d = no_gaps ? 0 : $urandom_range(0, 12);
      if (hold_req) begin
        d = LongHold;
        hold_req = 1'b0;
      end
      if (d > 0) begin
        out_stall_i <= 1'b1;
        repeat (d) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(logic reg_idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // one input transaction, followed by a random gap
  task automatic send_item(logic [2:0] op, logic [3:0] p, logic [2:0] r,
                           logic [15:0] amt, logic fin);
    int gap;
    opcode_i <= op;
    process_i <= p;
    resource_i <= r;
    amount_i <= amt;
    final_element_i <= fin;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every expected result has come
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  function automatic logic [15:0] pick_amount(int small_max);
    case ($urandom_range(0, 19))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, small_max));
    endcase
  endfunction

  function automatic logic [3:0] pick_proc();
    if ($urandom_range(0, 15) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, cur_procs - 1));
  endfunction

  function automatic logic [2:0] pick_res();
    if ($urandom_range(0, 15) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(0, cur_res - 1));
  endfunction

  task automatic set_config(int procs, int res);
    drain();
    write_reg(bda_pkg::RegProcCount, 32'(procs));
    write_reg(bda_pkg::RegResCount, 32'(res));
    cur_procs = (procs < 1) ? 1 : (procs > 16) ? 16 : procs;
    cur_res = (res < 1) ? 1 : (res > 8) ? 8 : res;
  endtask

  // request: elements for resources in order, each may be skipped at random, final on a random resource
  task automatic send_request();
    logic [3:0] p;
    int j;
    p = pick_proc();
    for (j = 0; j < cur_res; j++) begin
      if ($urandom_range(0, 9) == 0) continue;
      send_item(bda_pkg::OP_REQUEST, p, 3'(j), pick_amount(3), 1'b0);
    end
    send_item(bda_pkg::OP_REQUEST, p, pick_res(), pick_amount(3), 1'b1);
  endtask

  // preload tables, then a random mix of loads, requests and checks
  task automatic run_phase(int mix_items, bit with_hold);
    logic [3:0] p;
    logic [2:0] r;
    int k;
    for (k = 0; k < cur_res; k++) begin
      send_item(bda_pkg::OP_LOAD_AVAIL, '0, 3'(k), pick_amount(30), 1'b0);
    end
    for (k = 0; k < 10; k++) begin
      p = pick_proc();
      r = pick_res();
      send_item(bda_pkg::OP_LOAD_CLAIM, p, r, pick_amount(15), 1'b0);
      send_item(bda_pkg::OP_LOAD_ALLOC, p, r, pick_amount(8), 1'b0);
    end
    for (k = 0; k < mix_items; k++) begin
      if (with_hold && k == mix_items / 2) hold_req = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          send_item(bda_pkg::OP_LOAD_CLAIM, pick_proc(), pick_res(), pick_amount(15), 1'b0);
        end
        4, 5, 6: begin
          send_item(bda_pkg::OP_LOAD_ALLOC, pick_proc(), pick_res(), pick_amount(8), 1'b0);
        end
        7, 8:        send_item(bda_pkg::OP_LOAD_AVAIL, '0, pick_res(), pick_amount(30), 1'b0);
        9, 10, 11, 12, 13: send_request();
        14, 15, 16:  send_item(bda_pkg::OP_CHECK, '0, '0, '0, 1'b0);
        17:          send_item(3'($urandom_range(5, 7)), 4'($urandom_range(0, 15)),
                               3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
        default:     send_item(bda_pkg::OP_REQUEST, pick_proc(), pick_res(), pick_amount(3),
                               1'($urandom));
      endcase
    end
  endtask

  initial begin
    int cfg_procs [7];
    int cfg_res   [7];
    cfg_procs = '{16, 1, 4, 0, 31, 6, 16};
    cfg_res   = '{8, 1, 3, 0, 15, 2, 8};
    cur_procs = 16;
    cur_res = 8;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tables at reset sizes, then a two-process scenario
    send_item(bda_pkg::OP_CHECK, '0, '0, '0, 1'b0);
    set_config(2, 1);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd0, 3'd0, 16'hFFFF, 1'b0);
    send_item(bda_pkg::OP_LOAD_ALLOC, 4'd0, 3'd0, 16'hFFFF, 1'b0);
    send_item(bda_pkg::OP_LOAD_ALLOC, 4'd1, 3'd0, 16'd1, 1'b0);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd0, 3'd0, 16'd5, 1'b0);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd1, 3'd0, 16'd4, 1'b0);
    send_item(bda_pkg::OP_LOAD_AVAIL, '0, 3'd0, 16'd3, 1'b0);
    send_item(bda_pkg::OP_CHECK, '0, '0, '0, 1'b0);
    send_item(bda_pkg::OP_REQUEST, 4'd1, 3'd0, 16'd2, 1'b0);
    send_item(bda_pkg::OP_REQUEST, 4'd9, 3'd0, 16'd1, 1'b1);
    send_item(bda_pkg::OP_REQUEST, 4'd1, 3'd0, 16'd5, 1'b1);
    send_item(bda_pkg::OP_LOAD_ALLOC, 4'd0, 3'd0, 16'd0, 1'b0);
    send_item(bda_pkg::OP_REQUEST, 4'd1, 3'd0, 16'd4, 1'b1);
    send_item(bda_pkg::OP_REQUEST, 4'd1, 3'd0, 16'd3, 1'b1);
    send_item(bda_pkg::OP_CHECK, '0, '0, '0, 1'b0);
    send_item(OpUnused, 4'hF, 3'h7, 16'hFFFF, 1'b1);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd5, 3'd0, 16'd7, 1'b0);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd0, 3'd7, 16'd7, 1'b0);
    send_item(bda_pkg::OP_LOAD_AVAIL, '0, 3'd3, 16'hAAAA, 1'b0);
    send_item(bda_pkg::OP_LOAD_CLAIM, 4'd1, 3'd0, 16'd0, 1'b0);
    send_item(bda_pkg::OP_LOAD_AVAIL, '0, 3'd0, 16'd0, 1'b0);
    send_item(bda_pkg::OP_REQUEST, 4'd1, 3'd0, 16'd0, 1'b1);
    send_item(bda_pkg::OP_CHECK, '0, '0, '0, 1'b0);

    // random phases over several sizes; one without gaps, one with a long hold
    for (int ph = 0; ph < 7; ph++) begin
      set_config(cfg_procs[ph], cfg_res[ph]);
      no_gaps = (ph == 2);
      run_phase(22, ph == 0);
    end
    no_gaps = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    $display("run covered %0d input and %0d result transactions, %0d safe sequences",
             item_count, result_count, sequence_count);
    if (fail_count == 0) begin
      $display("[bankers_deadlock_avoidance] OK");
    end else begin
      $display("[bankers_deadlock_avoidance] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bda_pkg.sv
rtl/bda_ctrl.sv
rtl/bda_dp.sv
rtl/bankers_deadlock_avoidance.sv
rtl/bda_checker.sv
tb/bda_checker.sv
tb/tb_bankers_deadlock_avoidance.sv
